// File: hw/rtl/pwi_pkg.sv
// ----------------------------------------------------------------------------
// pwi_pkg
// Types, codes and sizes shared by the particle wall interaction unit.
// ----------------------------------------------------------------------------
package pwi_pkg;

    localparam int NUM_SLOTS_DEF = 4;

    localparam int IN_W       = 280;
    localparam int OUT_W      = 184;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WALL_IDS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KINDS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICT    = 3'd4;

    // slot kinds
    localparam logic [1:0] KIND_ESCAPE  = 2'd0;
    localparam logic [1:0] KIND_STICK   = 2'd1;
    localparam logic [1:0] KIND_REBOUND = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    localparam logic [7:0] KINDS_RESET = 8'hAA;

    // rebound sequence steps
    localparam logic [3:0] S_DOT0   = 4'd0;
    localparam logic [3:0] S_DOT1   = 4'd1;
    localparam logic [3:0] S_DOT2   = 4'd2;
    localparam logic [3:0] S_DOTSUM = 4'd3;
    localparam logic [3:0] S_NP0    = 4'd4;
    localparam logic [3:0] S_NP1    = 4'd5;
    localparam logic [3:0] S_NP2    = 4'd6;
    localparam logic [3:0] S_NPEND  = 4'd7;
    localparam logic [3:0] S_RST0   = 4'd8;
    localparam logic [3:0] S_RST1   = 4'd9;
    localparam logic [3:0] S_RST2   = 4'd10;
    localparam logic [3:0] S_FRC0   = 4'd11;
    localparam logic [3:0] S_FRC1   = 4'd12;
    localparam logic [3:0] S_FRC2   = 4'd13;
    localparam logic [3:0] S_FRCEND = 4'd14;
    localparam logic [3:0] S_OUT    = 4'd15;

    localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CALC = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic [31:0]        parcel_mass;
        logic signed [31:0] wall_vel_z;
        logic signed [31:0] wall_vel_y;
        logic signed [31:0] wall_vel_x;
        logic signed [15:0] normal_z;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_x;
        logic signed [31:0] vel_z;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic [7:0]         wall_id;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         pad;
        logic               bad_kind;
        logic [47:0]        slot_event_mass;
        logic [31:0]        slot_event_count;
        logic signed [31:0] out_vel_z;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_x;
        logic               still_active;
        logic               keep_particle;
        logic               handled;
    } t_out_item;

endpackage

// File: hw/rtl/particle_wall_interaction_unit.sv
// ----------------------------------------------------------------------------
// particle_wall_interaction_unit
// Matches a wall hit against four slots and applies escape, stick or a
// restitution and friction rebound, keeping saturating per-slot totals.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  s item   | in        | i_s_tvalid/o_s_tready  | i_s_tdata  (280 bits)
//  m item   | out       | o_m_tvalid/i_m_tready  | o_m_tdata  (184 bits)
//  cfg      | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One item at a time. A rebound runs 16 steps on one shared 42x18 multiplier
//  (three dot terms, three normal parts, three restitution, three friction
//  terms) before its result shows; other items skip the step sequence.
//  The next item is accepted in the cycle after the result is taken.
//  Reset is synchronous: clears state, config, slot totals; kinds to rebound.
//  A stalled result holds in its output register.
// ----------------------------------------------------------------------------
module particle_wall_interaction_unit #(
    parameter int NUM_SLOTS = pwi_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // wall_id, vel_x, vel_y, vel_z, normal_x, normal_y, normal_z,
    // wall_vel_x, wall_vel_y, wall_vel_z, parcel_mass
    input  logic [pwi_pkg::IN_W-1:0]        i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // handled, keep_particle, still_active, out_vel_x, out_vel_y, out_vel_z,
    // slot_event_count, slot_event_mass, bad_kind, zero pad
    output logic [pwi_pkg::OUT_W-1:0]       o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pwi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pwi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import pwi_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
        logic signed [31:0] y;
        if (x[44:31] == {14{x[44]}}) begin
            y = x[31:0];
        end else if (x[44]) begin
            y = {1'b1, 31'b0};
        end else begin
            y = {1'b0, {31{1'b1}}};
        end
        return y;
    endfunction

    t_state             r_state;
    t_state             n_state;
    logic [3:0]         r_step;

    logic [31:0]        r_ids;
    logic [3:0]         r_en;
    logic [7:0]         r_kinds;
    logic [63:0]        r_restit;
    logic [63:0]        r_frict;

    logic [31:0]        r_esc_cnt  [NUM_SLOTS];
    logic [47:0]        r_esc_mass [NUM_SLOTS];
    logic [31:0]        r_stk_cnt  [NUM_SLOTS];
    logic [47:0]        r_stk_mass [NUM_SLOTS];

    logic               r_hit;
    logic [SLOT_W-1:0]  r_slot;
    logic [1:0]         r_kind;
    logic signed [31:0] r_v [3];
    logic signed [31:0] r_w [3];
    logic signed [15:0] r_n [3];
    logic signed [43:0] r_u [3];
    logic signed [41:0] r_np [3];
    logic signed [41:0] r_ut [3];
    logic [31:0]        r_mass;
    logic signed [17:0] r_f;
    logic signed [17:0] r_mu;
    logic signed [59:0] r_prod;
    logic signed [51:0] r_dot;
    t_out_item          r_out;

    t_in_item           in_item;
    logic               match_hit;
    logic [SLOT_W-1:0]  match_slot;
    logic signed [41:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [59:0] mul_p;
    logic signed [45:0] prod_rnd;
    logic signed [41:0] un;
    logic               dot_pos;
    logic               rebound;
    logic               tally;
    logic [31:0]        cur_cnt;
    logic [47:0]        cur_mass;
    logic [31:0]        new_cnt;
    logic [48:0]        mass_sum;
    logic [47:0]        new_mass;

    assign in_item    = t_in_item'(i_s_tdata);
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_DONE);
    assign o_m_tdata  = r_out;
    assign o_cfg_ready = 1'b1;

    assign rebound  = r_hit && (r_kind == KIND_REBOUND);
    assign tally    = r_hit && ((r_kind == KIND_ESCAPE) || (r_kind == KIND_STICK));
    assign mul_p    = mul_a * mul_b;
    assign prod_rnd = 46'((r_prod + 60'sd8192) >>> 14);
    assign un       = 42'($signed(r_dot[51:14]));
    assign dot_pos  = (r_dot > 52'sd8192);

    assign cur_cnt  = (r_kind == KIND_ESCAPE) ? r_esc_cnt[r_slot]  : r_stk_cnt[r_slot];
    assign cur_mass = (r_kind == KIND_ESCAPE) ? r_esc_mass[r_slot] : r_stk_mass[r_slot];
    assign new_cnt  = (cur_cnt == '1) ? cur_cnt : cur_cnt + 32'd1;
    assign mass_sum = {1'b0, cur_mass} + 49'(r_mass);
    assign new_mass = mass_sum[48] ? '1 : mass_sum[47:0];

    always_comb begin
        match_hit  = 1'b0;
        match_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_en[i] && (r_ids[8*i +: 8] == in_item.wall_id)) begin
                match_hit  = 1'b1;
                match_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            S_DOT0: begin
                mul_a = 42'(r_u[0]);
                mul_b = 18'(r_n[0]);
            end
            S_DOT1: begin
                mul_a = 42'(r_u[1]);
                mul_b = 18'(r_n[1]);
            end
            S_DOT2: begin
                mul_a = 42'(r_u[2]);
                mul_b = 18'(r_n[2]);
            end
            S_NP0: begin
                mul_a = un;
                mul_b = 18'(r_n[0]);
            end
            S_NP1: begin
                mul_a = un;
                mul_b = 18'(r_n[1]);
            end
            S_NP2: begin
                mul_a = un;
                mul_b = 18'(r_n[2]);
            end
            S_RST0: begin
                mul_a = r_np[0];
                mul_b = r_f;
            end
            S_RST1: begin
                mul_a = r_np[1];
                mul_b = r_f;
            end
            S_RST2: begin
                mul_a = r_np[2];
                mul_b = r_f;
            end
            S_FRC0: begin
                mul_a = r_ut[0];
                mul_b = r_mu;
            end
            S_FRC1: begin
                mul_a = r_ut[1];
                mul_b = r_mu;
            end
            S_FRC2: begin
                mul_a = r_ut[2];
                mul_b = r_mu;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (!rebound || (r_step == S_OUT)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_m_tready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= S_DOT0;
            r_ids    <= '0;
            r_en     <= '0;
            r_kinds  <= KINDS_RESET;
            r_restit <= '0;
            r_frict  <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_esc_cnt[i]  <= '0;
                r_esc_mass[i] <= '0;
                r_stk_cnt[i]  <= '0;
                r_stk_mass[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_prod  <= mul_p;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WALL_IDS: r_ids    <= i_cfg_data[31:0];
                    CFG_ENABLE:   r_en     <= i_cfg_data[3:0];
                    CFG_KINDS:    r_kinds  <= i_cfg_data[7:0];
                    CFG_RESTIT:   r_restit <= i_cfg_data;
                    CFG_FRICT:    r_frict  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        r_step <= S_DOT0;
                        r_hit  <= match_hit;
                        r_slot <= match_slot;
                        r_kind <= r_kinds[2*match_slot +: 2];
                        r_f    <= 18'(r_restit[16*match_slot +: 16]) + ONE_Q14;
                        r_mu   <= 18'(r_frict[16*match_slot +: 16]);
                        r_mass <= in_item.parcel_mass;
                        r_v[0] <= in_item.vel_x;
                        r_v[1] <= in_item.vel_y;
                        r_v[2] <= in_item.vel_z;
                        r_w[0] <= in_item.wall_vel_x;
                        r_w[1] <= in_item.wall_vel_y;
                        r_w[2] <= in_item.wall_vel_z;
                        r_n[0] <= in_item.normal_x;
                        r_n[1] <= in_item.normal_y;
                        r_n[2] <= in_item.normal_z;
                        r_u[0] <= 44'(in_item.vel_x) - 44'(in_item.wall_vel_x);
                        r_u[1] <= 44'(in_item.vel_y) - 44'(in_item.wall_vel_y);
                        r_u[2] <= 44'(in_item.vel_z) - 44'(in_item.wall_vel_z);
                    end
                end
                ST_CALC: begin
                    r_step <= r_step + 4'd1;
                    if (!rebound) begin
                        r_out.pad           <= '0;
                        r_out.handled       <= r_hit;
                        r_out.keep_particle <= !(r_hit && (r_kind == KIND_ESCAPE));
                        r_out.still_active  <= 1'b0;
                        r_out.bad_kind      <= r_hit && (r_kind == KIND_INVALID);
                        r_out.out_vel_x     <= tally ? '0 : r_v[0];
                        r_out.out_vel_y     <= tally ? '0 : r_v[1];
                        r_out.out_vel_z     <= tally ? '0 : r_v[2];
                        r_out.slot_event_count <= tally ? new_cnt  : '0;
                        r_out.slot_event_mass  <= tally ? new_mass : '0;
                        if (tally && (r_kind == KIND_ESCAPE)) begin
                            r_esc_cnt[r_slot]  <= new_cnt;
                            r_esc_mass[r_slot] <= new_mass;
                        end
                        if (tally && (r_kind == KIND_STICK)) begin
                            r_stk_cnt[r_slot]  <= new_cnt;
                            r_stk_mass[r_slot] <= new_mass;
                        end
                    end else begin
                        case (r_step)
                            S_DOT1: r_dot <= 52'(r_prod) + 52'sd8192;
                            S_DOT2: r_dot <= r_dot + 52'(r_prod);
                            S_DOTSUM: r_dot <= r_dot + 52'(r_prod);
                            S_NP1: r_np[0] <= 42'(prod_rnd);
                            S_NP2: begin
                                r_np[1] <= 42'(prod_rnd);
                                r_ut[0] <= 42'(r_u[0] - 44'(r_np[0]));
                            end
                            S_NPEND: begin
                                r_np[2] <= 42'(prod_rnd);
                                r_ut[1] <= 42'(r_u[1] - 44'(r_np[1]));
                            end
                            S_RST0: r_ut[2] <= 42'(r_u[2] - 44'(r_np[2]));
                            S_RST1: begin
                                if (dot_pos) r_u[0] <= r_u[0] - 44'(prod_rnd);
                            end
                            S_RST2: begin
                                if (dot_pos) r_u[1] <= r_u[1] - 44'(prod_rnd);
                            end
                            S_FRC0: begin
                                if (dot_pos) r_u[2] <= r_u[2] - 44'(prod_rnd);
                            end
                            S_FRC1: r_u[0] <= r_u[0] - 44'(prod_rnd);
                            S_FRC2: r_u[1] <= r_u[1] - 44'(prod_rnd);
                            S_FRCEND: r_u[2] <= r_u[2] - 44'(prod_rnd);
                            S_OUT: begin
                                r_out.pad              <= '0;
                                r_out.handled          <= 1'b1;
                                r_out.keep_particle    <= 1'b1;
                                r_out.still_active     <= 1'b1;
                                r_out.bad_kind         <= 1'b0;
                                r_out.slot_event_count <= '0;
                                r_out.slot_event_mass  <= '0;
                                r_out.out_vel_x <= sat32(45'(r_u[0]) + 45'(r_w[0]));
                                r_out.out_vel_y <= sat32(45'(r_u[1]) + 45'(r_w[1]));
                                r_out.out_vel_z <= sat32(45'(r_u[2]) + 45'(r_w[2]));
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
